// ===== rtl/core/bcdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Click detector package
// Shared types and constants for the two-button click detector.
// ----------------------------------------------------------------------------
package bcdd_pkg;

   // Tick count and deadline widths. The deadline keeps one extra bit so that
   // it never wraps.
   localparam int unsigned TimeWidth     = 32;
   localparam int unsigned DeadlineWidth = TimeWidth + 1;
   localparam int unsigned DelayWidth    = 8;

   // Configuration register indexes.
   localparam logic [1:0] RegJoystickPresent  = 2'd0;
   localparam logic [1:0] RegDoubleClickEnable = 2'd1;
   localparam logic [1:0] RegDoubleClickDelay  = 2'd2;

   // Input word kinds, carried on tuser.
   localparam logic ModePoll  = 1'b0;
   localparam logic ModeFlush = 1'b1;

   // Event kinds, carried on tuser of the result channel.
   localparam logic KindSingle = 1'b0;
   localparam logic KindDouble = 1'b1;

   // Per-button click machine phases.
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_DOWN  = 4'b0010,
      PH_WAIT  = 4'b0100,
      PH_DOWN2 = 4'b1000
   } phase_type;

   // What one button lane found on a poll.
   typedef struct packed {
      logic fire;
      logic kind;
   } lane_event_type;

   // One queued result word.
   typedef struct packed {
      logic button;
      logic kind;
      logic last;
   } result_type;

endpackage

// ===== rtl/core/bcdd_lane.sv =====
// ----------------------------------------------------------------------------
// Button lane
// Click / double-click machine and deadline register for one button.
// ----------------------------------------------------------------------------
module bcdd_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic                                  flush,
   input  logic                                  down,
   input  logic [bcdd_pkg::TimeWidth-1:0]        now_time,
   input  logic                                  dc_enable,
   input  logic [bcdd_pkg::DelayWidth-1:0]       dc_delay,
   output bcdd_pkg::lane_event_type              ev
);
   import bcdd_pkg::*;

   phase_type                  phase_ff, phase_in;
   logic [DeadlineWidth-1:0]   deadline_ff, deadline_in;

   phase_type                  ph_cur;
   phase_type                  ph_next;
   logic [DeadlineWidth-1:0]   now_ext;
   logic [DeadlineWidth-1:0]   deadline_new;
   logic                       timeout;
   logic                       fire;
   logic                       kind;

   assign now_ext      = {1'b0, now_time};
   assign deadline_new = now_ext + DeadlineWidth'(dc_delay);
   assign timeout      = (phase_ff == PH_WAIT) && (deadline_ff <= now_ext);

   // Deadline check first, then the phase step on the button level.
   always_comb begin
      ph_cur      = timeout ? PH_IDLE : phase_ff;
      ph_next     = ph_cur;
      fire        = timeout;
      kind        = KindSingle;
      deadline_in = deadline_ff;
      unique case (ph_cur)
         PH_IDLE: begin
            if (down) ph_next = PH_DOWN;
         end
         PH_DOWN: begin
            if (!down) begin
               if (dc_enable) begin
                  deadline_in = deadline_new;
                  ph_next     = PH_WAIT;
               end else begin
                  fire    = 1'b1;
                  ph_next = PH_IDLE;
               end
            end
         end
         PH_WAIT: begin
            if (down) ph_next = PH_DOWN2;
         end
         PH_DOWN2: begin
            if (!down) begin
               fire    = 1'b1;
               kind    = KindDouble;
               ph_next = PH_IDLE;
            end
         end
         default: begin
            ph_next = PH_IDLE;
         end
      endcase
      if (!step) deadline_in = deadline_ff;
   end

   // A flush only clears the phase; the deadline is kept.
   always_comb begin
      if (step) begin
         phase_in = ph_next;
      end else if (flush) begin
         phase_in = PH_IDLE;
      end else begin
         phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         deadline_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         deadline_ff <= deadline_in;
      end
   end

   assign ev.fire = step && fire;
   assign ev.kind = kind;

endmodule

// ===== rtl/core/bcdd_merge.sv =====
// ----------------------------------------------------------------------------
// Event merge queue
// Orders the two lanes' events (button 0 first), marks the last event of a
// poll and holds them in a four-word queue in front of the result port.
// ----------------------------------------------------------------------------
module bcdd_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  bcdd_pkg::lane_event_type  ev0,
   input  bcdd_pkg::lane_event_type  ev1,
   output logic                      room,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      rsp_button,
   output logic                      rsp_kind,
   output logic                      rsp_last
);
   import bcdd_pkg::*;

   localparam int unsigned Depth = 4;

   result_type   q_ff [Depth];
   result_type   q_in [Depth];
   logic [2:0]   count_ff, count_in;

   result_type   first_word;
   result_type   second_word;
   logic [1:0]   push_n;
   logic         pop;
   logic [2:0]   base;
   logic [1:0]   tail_idx;

   // Lane 0's event goes out before lane 1's.
   always_comb begin
      push_n             = {1'b0, ev0.fire} + {1'b0, ev1.fire};
      first_word.button  = ev0.fire ? 1'b0 : 1'b1;
      first_word.kind    = ev0.fire ? ev0.kind : ev1.kind;
      first_word.last    = (push_n == 2'd1);
      second_word.button = 1'b1;
      second_word.kind   = ev1.kind;
      second_word.last   = 1'b1;
   end

   assign pop  = rsp_tvalid && rsp_tready;
   assign base = count_ff - {2'b00, pop};

   // Shift out the head on a pop, then append the new words behind.
   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         if (pop && (i < Depth - 1)) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if ((push_n != 2'd0) && (3'(i) == base)) q_in[i] = first_word;
         if ((push_n == 2'd2) && (3'(i) == base + 3'd1)) q_in[i] = second_word;
      end
      count_in = base + {1'b0, push_n};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // A poll may add two words, so at most two may be waiting.
   assign room       = (count_ff <= 3'd2);
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_button = q_ff[0].button;
   assign rsp_kind   = q_ff[0].kind;
   assign rsp_last   = q_ff[0].last;

   assign tail_idx = 2'(count_ff - 3'd1);

   // The queue never overfills.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(Depth))
      else $error("merge queue count out of range");

   // Two events with no drain grow the queue by two.
   a_push_two: assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2 && !pop) |=> (count_ff == $past(count_ff) + 3'd2))
      else $error("merge queue lost a word");

   // Every poll's run ends in a word marked last, so the newest word is.
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 3'd0) |-> q_ff[tail_idx].last)
      else $error("newest queued word not marked last");

   // No new words arrive unless there was room for them.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> room)
      else $error("push into full merge queue");

endmodule

// ===== rtl/core/button_click_double_click_detector.sv =====
// A poll's first event word is offered on rsp the cycle after it is accepted when no
// earlier word is still queued. Throughput: a poll is taken every cycle while the
// result queue holds two words or fewer; polls giving two events each are limited
// by the single result port, which drains one word per cycle while rsp_tready is high.
// Reset (synchronous, active high): both buttons idle, deadlines and registers zero.
// ----------------------------------------------------------------------------
// Click and double-click detector
// Two button lanes step in parallel on each poll while the joystick is present;
// a merge queue serializes their click events onto one result stream.
// ----------------------------------------------------------------------------
module button_click_double_click_detector (
   input  logic        clock,
   input  logic        reset,
   // Poll / flush words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [31:0] now_time, [32] button0_pressed,
                                   // [33] button1_pressed, [39:34] zero
   input  logic        req_tuser,  // [0] mode
   // Click events
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [0] button_index, [7:1] zero
   output logic        rsp_tuser,  // [0] event_kind
   output logic        rsp_tlast,  // last_of_run
   // Register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import bcdd_pkg::*;

   logic                    present_ff, present_in;
   logic                    dc_enable_ff, dc_enable_in;
   logic [DelayWidth-1:0]   dc_delay_ff, dc_delay_in;

   logic                    accept;
   logic                    step;
   logic                    flush;
   logic                    room;
   logic                    rsp_button;
   lane_event_type          ev0;
   lane_event_type          ev1;

   // Register write decode.
   assign csr_ready = 1'b1;

   always_comb begin
      present_in   = present_ff;
      dc_enable_in = dc_enable_ff;
      dc_delay_in  = dc_delay_ff;
      if (csr_valid) begin
         unique case (csr_index)
            RegJoystickPresent:   present_in   = csr_data[0];
            RegDoubleClickEnable: dc_enable_in = csr_data[0];
            RegDoubleClickDelay:  dc_delay_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= 1'b0;
         dc_enable_ff <= 1'b0;
         dc_delay_ff  <= '0;
      end else begin
         present_ff   <= present_in;
         dc_enable_ff <= dc_enable_in;
         dc_delay_ff  <= dc_delay_in;
      end
   end

   // Input word handling.
   assign req_tready = room;
   assign accept     = req_tvalid && req_tready;
   assign flush      = accept && (req_tuser == ModeFlush);
   assign step       = accept && (req_tuser == ModePoll) && present_ff;

   // One lane per button.
   bcdd_lane u_lane0 (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .flush     (flush),
      .down      (req_tdata[TimeWidth]),
      .now_time  (req_tdata[TimeWidth-1:0]),
      .dc_enable (dc_enable_ff),
      .dc_delay  (dc_delay_ff),
      .ev        (ev0)
   );

   bcdd_lane u_lane1 (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .flush     (flush),
      .down      (req_tdata[TimeWidth+1]),
      .now_time  (req_tdata[TimeWidth-1:0]),
      .dc_enable (dc_enable_ff),
      .dc_delay  (dc_delay_ff),
      .ev        (ev1)
   );

   bcdd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ev0        (ev0),
      .ev1        (ev1),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_button (rsp_button),
      .rsp_kind   (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_button};

endmodule

// ===== tb/click_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click event checker
// Watches the request, result and register channels of the click detector.
// Every accepted poll made while the joystick is present runs through an
// independent model of the two button machines. The click words it predicts
// are queued and compared, field by field, with the words the block returns.
// ----------------------------------------------------------------------------
module click_event_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          mismatch_count,
   output int          clicks_pending,
   output int          polls_seen,
   output int          flushes_seen,
   output int          singles_seen,
   output int          doubles_seen
);
   import bcdd_pkg::*;

   // Model copy of the registers and of the per-button state.
   logic                     present_reg;
   logic                     double_enable_reg;
   logic [DelayWidth-1:0]    delay_reg;
   phase_type                click_state [2];
   logic [DeadlineWidth-1:0] click_deadline_q [2];

   // Click words predicted but not yet returned, oldest first.
   result_type expected_clicks [$];

   // Count a bad word and describe the first few of them.
   task automatic flag_click(input bit have_want, input result_type want,
                             input result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (have_want)
            $display({"[%0t] click word mismatch: expected button %0d kind %0d",
                      " last %0d, got button %0d kind %0d last %0d"},
                     $realtime, want.button, want.kind, want.last,
                     got.button, got.kind, got.last);
         else
            $display("[%0t] unexpected click word: button %0d kind %0d last %0d",
                     $realtime, got.button, got.kind, got.last);
      end
   endtask

   // Step both button machines for one poll and queue the click words.
   task automatic predict_clicks(input logic [TimeWidth-1:0] now,
                                 input logic [1:0] down);
      result_type found [$];
      result_type word;
      phase_type  ph;
      for (int b = 0; b < 2; b++) begin
         ph = click_state[b];
         word.button = 1'(b);
         word.last   = 1'b0;
         // An expired wait reports a single click, then the poll goes on from idle.
         if (ph == PH_WAIT && click_deadline_q[b] <= {1'b0, now}) begin
            ph        = PH_IDLE;
            word.kind = KindSingle;
            found.push_back(word);
         end
         case (ph)
            PH_IDLE: begin
               if (down[b]) ph = PH_DOWN;
            end
            PH_DOWN: begin
               if (!down[b]) begin
                  if (double_enable_reg) begin
                     click_deadline_q[b] = {1'b0, now} + DeadlineWidth'(delay_reg);
                     ph = PH_WAIT;
                  end else begin
                     word.kind = KindSingle;
                     found.push_back(word);
                     ph = PH_IDLE;
                  end
               end
            end
            PH_WAIT: begin
               if (down[b]) ph = PH_DOWN2;
            end
            default: begin
               if (!down[b]) begin
                  word.kind = KindDouble;
                  found.push_back(word);
                  ph = PH_IDLE;
               end
            end
         endcase
         click_state[b] = ph;
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) expected_clicks.push_back(found[i]);
   endtask

   // All three channels are sampled at the rising edge. Results are checked
   // before the same edge's poll is modeled, since a poll's words come later.
   // A poll at the same edge as a register write still sees the old setting.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         present_reg       = 1'b0;
         double_enable_reg = 1'b0;
         delay_reg         = '0;
         for (int b = 0; b < 2; b++) begin
            click_state[b]      = PH_IDLE;
            click_deadline_q[b] = '0;
         end
         expected_clicks.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.button = rsp_tdata[0];
            got.kind   = rsp_tuser;
            got.last   = rsp_tlast;
            if (got.kind == KindDouble) doubles_seen++;
            else singles_seen++;
            if (expected_clicks.size() == 0) begin
               flag_click(1'b0, '0, got);
            end else begin
               want = expected_clicks.pop_front();
               if (got !== want) flag_click(1'b1, want, got);
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == ModeFlush) begin
               // Flush idles both machines but keeps the deadlines.
               flushes_seen++;
               click_state[0] = PH_IDLE;
               click_state[1] = PH_IDLE;
            end else begin
               polls_seen++;
               if (present_reg) predict_clicks(req_tdata[31:0], req_tdata[33:32]);
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegJoystickPresent:   present_reg       = csr_data[0];
               RegDoubleClickEnable: double_enable_reg = csr_data[0];
               RegDoubleClickDelay:  delay_reg         = csr_data;
               default: ;
            endcase
         end
      end
      clicks_pending = expected_clicks.size();
   end

endmodule

// ===== tb/button_click_double_click_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click detector testbench
// Drives polls, flushes and register writes into the two-button click
// detector: a directed opening on the corner cases, a burst against a held-off
// receiver, then random click gestures under four idling patterns. A checker
// beside the block predicts and compares every click word.
// ----------------------------------------------------------------------------
module button_click_double_click_detector_test;
   import bcdd_pkg::*;

   localparam logic [1:0] RegUnused     = 2'd3;
   localparam int         WatchdogLimit = 5000;
   localparam int         HoldOffCycles = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [31:0] now_time, [32] button0, [33] button1
   logic        req_tuser = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;       // [0] button_index
   logic        rsp_tuser;       // [0] event_kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   int          mismatch_count;
   int          clicks_pending;
   int          polls_seen;
   int          flushes_seen;
   int          singles_seen;
   int          doubles_seen;

   int          sender_idle_pct = 0;
   int          rsp_stall_pct = 0;
   bit          hold_request = 1'b0;
   int          stall_cycles = 0;
   logic [31:0] tick = '0;
   logic [1:0]  levels = '0;
   logic [7:0]  delay_setting = '0;

   always #4 clock = ~clock;

   button_click_double_click_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   click_event_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .clicks_pending (clicks_pending),
      .polls_seen     (polls_seen),
      .flushes_seen   (flushes_seen),
      .singles_seen   (singles_seen),
      .doubles_seen   (doubles_seen)
   );

   // Result side: random stalls, plus one long hold-off when asked for.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready   = 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         rsp_tready = (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: too long without any word moving on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
         $display("Watchdog: no word moved for %0d cycles", WatchdogLimit);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one request word, with random idle cycles ahead of it.
   task automatic send_word(input logic mode, input logic [31:0] now,
                            input logic [1:0] down);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {6'd0, down, now};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Register writes wait until the block has nothing left in flight.
   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      req_tvalid = 1'b0;
      while (clicks_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (index == RegDoubleClickDelay) delay_setting = value;
   endtask

   // Time advance: mostly around the double-click window, sometimes far past it.
   function automatic logic [31:0] time_step(input logic [7:0] delay);
      case ($urandom_range(3))
         0:       return $urandom_range(2);
         1:       return $urandom_range(delay + 2);
         2:       return delay + $urandom_range(1);
         default: return $urandom_range(600);
      endcase
   endfunction

   // One random word: mostly button gestures on a rising clock, some noise.
   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 3) begin
         send_word(ModeFlush, $urandom, 2'($urandom));
      end else if (pick < 12) begin
         if (pick < 7) tick = $urandom;
         levels = 2'($urandom);
         send_word(ModePoll, tick, levels);
      end else begin
         if ($urandom_range(99) < 40) levels[0] = ~levels[0];
         if ($urandom_range(99) < 40) levels[1] = ~levels[1];
         tick = tick + time_step(delay_setting);
         send_word(ModePoll, tick, levels);
      end
   endtask

   // New register settings for a stretch of random words.
   task automatic configure_segment();
      logic [7:0] delay;
      case ($urandom_range(3))
         0:       delay = 8'd0;
         1:       delay = 8'd255;
         2:       delay = 8'($urandom_range(1, 20));
         default: delay = 8'($urandom);
      endcase
      if ($urandom_range(9) == 0)
         write_csr(RegJoystickPresent, 8'($urandom) & 8'hFE);
      else
         write_csr(RegJoystickPresent, 8'($urandom) | 8'h01);
      write_csr(RegDoubleClickEnable, 8'($urandom));
      write_csr(RegDoubleClickDelay, delay);
      if ($urandom_range(3) == 0) write_csr(RegUnused, 8'($urandom));
      // Now and then run the tick count across its wrap.
      if ($urandom_range(7) == 0) tick = 32'hFFFF_FFFF - $urandom_range(400);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Joystick absent after reset: polls change nothing, flush still works.
      send_word(ModePoll, 32'd5, 2'b11);
      send_word(ModePoll, 32'd6, 2'b00);
      send_word(ModeFlush, 32'hFFFF_FFFF, 2'b11);

      // Double-click off: both buttons click at once on release, button 0 first.
      write_csr(RegJoystickPresent, 8'hFF);
      write_csr(RegDoubleClickEnable, 8'hFE);
      write_csr(RegDoubleClickDelay, 8'hFF);
      send_word(ModePoll, 32'd0, 2'b11);
      send_word(ModePoll, 32'd1, 2'b00);

      // Double-click on: a second press within the window is a double click.
      write_csr(RegDoubleClickEnable, 8'h01);
      send_word(ModePoll, 32'd100, 2'b01);
      send_word(ModePoll, 32'd110, 2'b00);
      send_word(ModePoll, 32'd200, 2'b01);
      send_word(ModePoll, 32'd210, 2'b00);

      // Deadline hit exactly: single click on button 1, while button 0 goes down.
      send_word(ModePoll, 32'd300, 2'b10);
      send_word(ModePoll, 32'd310, 2'b00);
      send_word(ModePoll, 32'd565, 2'b01);
      send_word(ModePoll, 32'd570, 2'b00);
      send_word(ModeFlush, 32'hFFFF_FFFF, 2'b11);

      // Deadline past the tick wrap is never reached; a second press still counts.
      send_word(ModePoll, 32'hFFFF_FFF0, 2'b11);
      send_word(ModePoll, 32'hFFFF_FFFF, 2'b00);
      send_word(ModePoll, 32'h0000_0500, 2'b00);
      send_word(ModePoll, 32'd5, 2'b11);
      send_word(ModePoll, 32'd6, 2'b00);

      // Zero delay: a poll earlier in time does not expire the wait.
      write_csr(RegDoubleClickDelay, 8'd0);
      send_word(ModePoll, 32'd1000, 2'b11);
      send_word(ModePoll, 32'd1000, 2'b00);
      send_word(ModePoll, 32'd999, 2'b00);
      send_word(ModePoll, 32'd1000, 2'b11);
      send_word(ModePoll, 32'd1001, 2'b00);

      // Turning double-click off mid-wait does not cut the pending click short.
      write_csr(RegDoubleClickEnable, 8'h00);
      send_word(ModePoll, 32'd1000, 2'b11);
      send_word(ModePoll, 32'd1000, 2'b00);

      write_csr(RegJoystickPresent, 8'h00);
      send_word(ModePoll, 32'd2000, 2'b11);

      // Receiver held off while polls keep coming, so the block backs up.
      write_csr(RegJoystickPresent, 8'h01);
      write_csr(RegDoubleClickEnable, 8'h00);
      levels       = 2'b00;
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++) begin
         levels = ~levels;
         tick   = tick + 1;
         send_word(ModePoll, tick, levels);
      end

      // Random gestures under each idling pattern.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 50; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 50; end
            default: begin sender_idle_pct = 28; rsp_stall_pct = 28; end
         endcase
         for (int s = 0; s < 2; s++) begin
            configure_segment();
            for (int i = 0; i < 160; i++) random_item();
         end
      end

      // Drain: wait for every predicted click, then a few quiet cycles.
      req_tvalid = 1'b0;
      while (clicks_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Covered %0d polls and %0d flushes; %0d click words (%0d single, %0d double).",
               polls_seen, flushes_seen, singles_seen + doubles_seen, singles_seen, doubles_seen);
      $display("Idling patterns: none, sender, receiver, both; one long receiver hold-off.");
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/bcdd_pkg.sv
rtl/core/bcdd_lane.sv
rtl/core/bcdd_merge.sv
rtl/core/button_click_double_click_detector.sv
tb/click_event_checker.sv
tb/button_click_double_click_detector_test.sv
